/* rtl/core/fwsk_pkg.sv */
// Shared types, widths and the arctangent table for the four-wheel steering kinematics block.
package fwsk_pkg;

	localparam int CORDIC_STAGES = 16;
	localparam int ATAN_ENTRIES = 24;
	localparam int CORDIC_ITERS = (CORDIC_STAGES < ATAN_ENTRIES) ? CORDIC_STAGES : ATAN_ENTRIES;

	localparam int IN_W = 16;
	localparam int OUT_W = 16;
	localparam int REG_W = 12;
	localparam int IDX_W = 3;

	// Wheel velocity in 2^-10 mm/s: 1024 * speed plus yaw times a lever of up to 13 bits.
	localparam int PROD_W = IN_W + REG_W + 2;
	localparam int VEL_W = PROD_W + 1;

	// CORDIC datapath and angle accumulator, where pi is 2^31.
	localparam int CW = VEL_W + 2;
	localparam int ZW = 34;
	localparam int ANG_LSB = 16;

	// Sum of squares stays below 2^57, so the root has 29 bits.
	localparam int SQ_W = 58;
	localparam int ROOT_W = SQ_W / 2;
	localparam int DIV_SHIFT = 4;
	localparam int DIV_W = ROOT_W - DIV_SHIFT;

	localparam int MAG_LAT = 3 + ROOT_W + DIV_W;
	localparam int ANG_LAT = CORDIC_ITERS + 2;
	localparam int ANG_DELAY = MAG_LAT - ANG_LAT;

	localparam logic [IDX_W-1:0] REG_FRONT_AXLE = 3'd0;
	localparam logic [IDX_W-1:0] REG_REAR_AXLE = 3'd1;
	localparam logic [IDX_W-1:0] REG_LEFT_TRACK = 3'd2;
	localparam logic [IDX_W-1:0] REG_RIGHT_TRACK = 3'd3;
	localparam logic [IDX_W-1:0] REG_WHEEL_RADIUS = 3'd4;
	localparam logic [IDX_W-1:0] REG_EXTENSION = 3'd5;

	localparam logic [1:0] WHEEL_FL = 2'd0;
	localparam logic [1:0] WHEEL_FR = 2'd1;
	localparam logic [1:0] WHEEL_RL = 2'd2;
	localparam logic [1:0] WHEEL_RR = 2'd3;

	typedef struct packed {
		logic signed [IN_W-1:0] v_right;
		logic signed [IN_W-1:0] v_fwd;
		logic signed [IN_W-1:0] turn_rate;
	} cmd_t;

	typedef struct packed {
		logic signed [OUT_W-1:0] steer_front_left;
		logic signed [OUT_W-1:0] steer_front_right;
		logic signed [OUT_W-1:0] steer_rear_left;
		logic signed [OUT_W-1:0] steer_rear_right;
		logic [OUT_W-1:0] rotor_front_left;
		logic [OUT_W-1:0] rotor_front_right;
		logic [OUT_W-1:0] rotor_rear_left;
		logic [OUT_W-1:0] rotor_rear_right;
	} res_t;

	typedef struct packed {
		logic [REG_W-1:0] front_axle_offset;
		logic [REG_W-1:0] rear_axle_offset;
		logic [REG_W-1:0] left_half_track;
		logic [REG_W-1:0] right_half_track;
		logic [REG_W-1:0] wheel_radius;
		logic [REG_W-1:0] extra_len;
	} cfg_t;

	typedef struct packed {
		logic valid;
		logic [1:0] wheel;
	} beat_t;

	function automatic logic [31:0] atan_val(input int unsigned k);
		logic [31:0] v;
		case (k)
			0: v = 32'd536870912;
			1: v = 32'd316933405;
			2: v = 32'd167458907;
			3: v = 32'd85004756;
			4: v = 32'd42667331;
			5: v = 32'd21354465;
			6: v = 32'd10679838;
			7: v = 32'd5340245;
			8: v = 32'd2670163;
			9: v = 32'd1335086;
			10: v = 32'd667544;
			11: v = 32'd333772;
			12: v = 32'd166886;
			13: v = 32'd83443;
			14: v = 32'd41721;
			15: v = 32'd20860;
			16: v = 32'd10430;
			17: v = 32'd5215;
			18: v = 32'd2607;
			19: v = 32'd1303;
			20: v = 32'd651;
			21: v = 32'd325;
			22: v = 32'd162;
			23: v = 32'd81;
			default: v = 32'd0;
		endcase
		return v;
	endfunction

endpackage

/* rtl/core/fwsk_vel.sv */
// Command sequencer and wheel velocity stages: one wheel beat per cycle while en is high.
module fwsk_vel import fwsk_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic en,
	input logic in_valid,
	output logic in_ready,
	input cmd_t in_data,
	input cfg_t cfg,
	output beat_t beat,
	output logic signed [VEL_W-1:0] vx,
	output logic signed [VEL_W-1:0] vy
);

	logic busy_q;
	logic [1:0] wheel_q;
	cmd_t cmd_q;
	logic accept;

	logic [REG_W:0] len_front;
	logic [REG_W:0] len_rear;
	logic signed [REG_W+1:0] coef_x;
	logic signed [REG_W+1:0] coef_y;
	logic signed [PROD_W-1:0] prod_x;
	logic signed [PROD_W-1:0] prod_y;

	beat_t beat_s1, beat_s2;
	logic signed [PROD_W-1:0] prod_x_s1, prod_y_s1;
	logic signed [IN_W-1:0] vr_s1, vf_s1;
	logic signed [VEL_W-1:0] vx_s2, vy_s2;

	// A new command is taken when idle or while the last wheel of the current one goes out.
	assign in_ready = en && (!busy_q || wheel_q == WHEEL_RR);
	assign accept = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			wheel_q <= WHEEL_FL;
		end else if (en) begin
			if (accept) begin
				busy_q <= 1'b1;
				wheel_q <= WHEEL_FL;
			end else if (busy_q) begin
				wheel_q <= wheel_q + 2'd1;
				if (wheel_q == WHEEL_RR) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= in_data;
		end
	end

	assign len_front = {1'b0, cfg.front_axle_offset} + {1'b0, cfg.extra_len};
	assign len_rear = {1'b0, cfg.rear_axle_offset} + {1'b0, cfg.extra_len};

	// Front wheels see -yaw * lever, rear wheels +yaw * lever; likewise left and right.
	always_comb begin
		if (wheel_q[1]) begin
			coef_x = $signed({1'b0, len_rear});
		end else begin
			coef_x = -$signed({1'b0, len_front});
		end
		if (wheel_q[0]) begin
			coef_y = $signed({2'b00, cfg.right_half_track});
		end else begin
			coef_y = -$signed({2'b00, cfg.left_half_track});
		end
	end

	assign prod_x = cmd_q.turn_rate * coef_x;
	assign prod_y = cmd_q.turn_rate * coef_y;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			beat_s1 <= '0;
			beat_s2 <= '0;
		end else if (en) begin
			beat_s1.valid <= busy_q;
			beat_s1.wheel <= wheel_q;
			beat_s2 <= beat_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_x_s1 <= prod_x;
			prod_y_s1 <= prod_y;
			vr_s1 <= cmd_q.v_right;
			vf_s1 <= cmd_q.v_fwd;
			vx_s2 <= {{(VEL_W-IN_W-10){vr_s1[IN_W-1]}}, vr_s1, 10'b0}
				+ {{(VEL_W-PROD_W){prod_x_s1[PROD_W-1]}}, prod_x_s1};
			vy_s2 <= {{(VEL_W-IN_W-10){vf_s1[IN_W-1]}}, vf_s1, 10'b0}
				+ {{(VEL_W-PROD_W){prod_y_s1[PROD_W-1]}}, prod_y_s1};
		end
	end

	assign beat = beat_s2;
	assign vx = vx_s2;
	assign vy = vy_s2;

endmodule

/* rtl/core/fwsk_cordic.sv */
// Pipelined vectoring CORDIC giving atan2(-vx, vy), delayed to match the magnitude path.
module fwsk_cordic import fwsk_pkg::*; (
	input logic clk,
	input logic en,
	input logic signed [VEL_W-1:0] vx,
	input logic signed [VEL_W-1:0] vy,
	output logic signed [OUT_W-1:0] angle
);

	localparam logic signed [ZW-1:0] Z_PI = {{(ZW-32){1'b0}}, 32'h8000_0000};
	localparam logic signed [ZW-1:0] Z_HALF = {{(ZW-ANG_LSB){1'b0}}, 1'b1, {(ANG_LSB-1){1'b0}}};

	logic signed [CW-1:0] x0, y0;
	logic signed [CW-1:0] x_s [0:CORDIC_ITERS];
	logic signed [CW-1:0] y_s [0:CORDIC_ITERS];
	logic signed [ZW-1:0] z_s [0:CORDIC_ITERS];
	logic zero_s [0:CORDIC_ITERS];
	logic signed [ZW-1:0] z_round;
	logic signed [OUT_W-1:0] ang_s;
	logic signed [OUT_W-1:0] dly_s [0:ANG_DELAY-1];

	assign x0 = {{(CW-VEL_W){vy[VEL_W-1]}}, vy};
	assign y0 = -{{(CW-VEL_W){vx[VEL_W-1]}}, vx};

	// A vector in the left half plane is turned by pi before the iterations.
	always_ff @(posedge clk) begin
		if (en) begin
			zero_s[0] <= (vx == '0) && (vy == '0);
			if (x0[CW-1]) begin
				x_s[0] <= -x0;
				y_s[0] <= -y0;
				z_s[0] <= y0[CW-1] ? -Z_PI : Z_PI;
			end else begin
				x_s[0] <= x0;
				y_s[0] <= y0;
				z_s[0] <= '0;
			end
		end
	end

	for (genvar k = 0; k < CORDIC_ITERS; k++) begin : g_iter
		localparam logic signed [ZW-1:0] T = ZW'(atan_val(k));
		always_ff @(posedge clk) begin
			if (en) begin
				zero_s[k+1] <= zero_s[k];
				if (y_s[k][CW-1]) begin
					x_s[k+1] <= x_s[k] - (y_s[k] >>> k);
					y_s[k+1] <= y_s[k] + (x_s[k] >>> k);
					z_s[k+1] <= z_s[k] - T;
				end else begin
					x_s[k+1] <= x_s[k] + (y_s[k] >>> k);
					y_s[k+1] <= y_s[k] - (x_s[k] >>> k);
					z_s[k+1] <= z_s[k] + T;
				end
			end
		end
	end

	assign z_round = z_s[CORDIC_ITERS] + Z_HALF;

	always_ff @(posedge clk) begin
		if (en) begin
			ang_s <= zero_s[CORDIC_ITERS] ? '0 : z_round[ANG_LSB+OUT_W-1:ANG_LSB];
			dly_s[0] <= ang_s;
			for (int j = 1; j < ANG_DELAY; j++) begin
				dly_s[j] <= dly_s[j-1];
			end
		end
	end

	assign angle = dly_s[ANG_DELAY-1];

endmodule

/* rtl/core/fwsk_mag.sv */
// Wheel speed pipeline: sum of squares, digit-by-digit square root, radius division and saturation.
module fwsk_mag import fwsk_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic en,
	input beat_t beat_in,
	input logic signed [VEL_W-1:0] vx,
	input logic signed [VEL_W-1:0] vy,
	input logic [REG_W-1:0] radius,
	output beat_t beat_out,
	output logic [OUT_W-1:0] rotor
);

	localparam int RW = ROOT_W + 1;

	beat_t ctl_s [0:MAG_LAT-1];
	logic signed [2*VEL_W-1:0] px, py;
	logic [SQ_W-1:0] sq_x_s1, sq_y_s1;
	logic [SQ_W-1:0] rad_s [0:ROOT_W];
	logic [RW-1:0] rem_s [0:ROOT_W];
	logic [ROOT_W-1:0] root_s [0:ROOT_W];
	logic [DIV_W-1:0] dn_s [1:DIV_W];
	logic [REG_W-1:0] dr_s [1:DIV_W];
	logic [DIV_W-1:0] dq_s [1:DIV_W];
	logic [REG_W-1:0] divisor;
	logic [DIV_W-1:0] quot;
	logic [OUT_W-1:0] rotor_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < MAG_LAT; j++) begin
				ctl_s[j] <= '0;
			end
		end else if (en) begin
			ctl_s[0] <= beat_in;
			for (int j = 1; j < MAG_LAT; j++) begin
				ctl_s[j] <= ctl_s[j-1];
			end
		end
	end

	assign px = vx * vx;
	assign py = vy * vy;

	always_ff @(posedge clk) begin
		if (en) begin
			sq_x_s1 <= px[SQ_W-1:0];
			sq_y_s1 <= py[SQ_W-1:0];
			rad_s[0] <= sq_x_s1 + sq_y_s1;
			rem_s[0] <= '0;
			root_s[0] <= '0;
		end
	end

	// One root bit per stage: bring down two radicand bits, try (root << 2) | 1.
	for (genvar k = 0; k < ROOT_W; k++) begin : g_sqrt
		logic [RW+1:0] rem_x;
		logic [RW+1:0] trial;
		logic fits;
		assign rem_x = {rem_s[k], rad_s[k][SQ_W-1 -: 2]};
		assign trial = {1'b0, root_s[k], 2'b01};
		assign fits = rem_x >= trial;
		always_ff @(posedge clk) begin
			if (en) begin
				rad_s[k+1] <= rad_s[k] << 2;
				if (fits) begin
					rem_s[k+1] <= RW'(rem_x - trial);
					root_s[k+1] <= {root_s[k][ROOT_W-2:0], 1'b1};
				end else begin
					rem_s[k+1] <= rem_x[RW-1:0];
					root_s[k+1] <= {root_s[k][ROOT_W-2:0], 1'b0};
				end
			end
		end
	end

	// A radius of zero divides as a radius of one.
	assign divisor = (radius == '0) ? {{(REG_W-1){1'b0}}, 1'b1} : radius;

	for (genvar k = 0; k < DIV_W; k++) begin : g_div
		logic [DIV_W-1:0] n_in, q_in;
		logic [REG_W-1:0] r_in;
		logic [REG_W:0] t;
		logic ge;
		if (k == 0) begin : g_first
			assign n_in = root_s[ROOT_W][ROOT_W-1:DIV_SHIFT];
			assign r_in = '0;
			assign q_in = '0;
		end else begin : g_next
			assign n_in = dn_s[k];
			assign r_in = dr_s[k];
			assign q_in = dq_s[k];
		end
		assign t = {r_in, n_in[DIV_W-1]};
		assign ge = t >= {1'b0, divisor};
		always_ff @(posedge clk) begin
			if (en) begin
				dn_s[k+1] <= n_in << 1;
				dq_s[k+1] <= {q_in[DIV_W-2:0], ge};
				if (ge) begin
					dr_s[k+1] <= REG_W'(t - {1'b0, divisor});
				end else begin
					dr_s[k+1] <= t[REG_W-1:0];
				end
			end
		end
	end

	assign quot = dq_s[DIV_W];

	always_ff @(posedge clk) begin
		if (en) begin
			rotor_s3 <= (|quot[DIV_W-1:OUT_W]) ? {OUT_W{1'b1}} : quot[OUT_W-1:0];
		end
	end

	assign beat_out = ctl_s[MAG_LAT-1];
	assign rotor = rotor_s3;

endmodule

/* rtl/core/four_wheel_steer_kinematics.sv */
// Top level of the four-wheel steering kinematics block: registers, pipeline and result assembly.
//
// Input channel (in_valid/in_ready/in_data) takes one body velocity command per beat;
// output channel (out_valid/out_ready/out_data) gives steer angle and rotor speed of all
// four wheels per beat. Configuration is written through cfg_we/cfg_addr/cfg_wdata and
// should change only while no command is in flight.
// The four wheels of a command go through one shared pipeline, one wheel per cycle while
// the pipeline is not held; a new command is taken while the last wheel of the current one
// is sequenced. The command rate is set by the wheel sequencer that feeds the single
// velocity, CORDIC and square-root/divider pipeline. Latency from input beat to output
// beat is set mostly by the 29-step square root and the 25-step divider.
// The result waits in an output register; while it is not taken, wheels keep flowing
// until the last wheel of the next command reaches the end, then the whole pipeline holds.
// Reset clears all valid bits and loads the default geometry (500 mm offsets and tracks,
// 200 mm radius, no extension).
module four_wheel_steer_kinematics import fwsk_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input cmd_t in_data,
	output logic out_valid,
	input logic out_ready,
	output res_t out_data,
	input logic cfg_we,
	input logic [IDX_W-1:0] cfg_addr,
	input logic [REG_W-1:0] cfg_wdata
);

	cfg_t cfg_q;
	logic en;
	beat_t vel_beat, mag_beat;
	logic signed [VEL_W-1:0] vx, vy;
	logic signed [OUT_W-1:0] angle;
	logic [OUT_W-1:0] rotor;

	logic signed [OUT_W-1:0] steer_fl_q, steer_fr_q, steer_rl_q;
	logic [OUT_W-1:0] rotor_fl_q, rotor_fr_q, rotor_rl_q;
	res_t out_q;
	logic out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.front_axle_offset <= 12'd500;
			cfg_q.rear_axle_offset <= 12'd500;
			cfg_q.left_half_track <= 12'd500;
			cfg_q.right_half_track <= 12'd500;
			cfg_q.wheel_radius <= 12'd200;
			cfg_q.extra_len <= 12'd0;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_FRONT_AXLE: cfg_q.front_axle_offset <= cfg_wdata;
				REG_REAR_AXLE: cfg_q.rear_axle_offset <= cfg_wdata;
				REG_LEFT_TRACK: cfg_q.left_half_track <= cfg_wdata;
				REG_RIGHT_TRACK: cfg_q.right_half_track <= cfg_wdata;
				REG_WHEEL_RADIUS: cfg_q.wheel_radius <= cfg_wdata;
				REG_EXTENSION: cfg_q.extra_len <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Only a finished last wheel facing a full, unread output register holds the pipeline.
	assign en = !(mag_beat.valid && mag_beat.wheel == WHEEL_RR && out_valid_q && !out_ready);

	fwsk_vel u_vel (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.cfg(cfg_q),
		.beat(vel_beat),
		.vx(vx),
		.vy(vy)
	);

	fwsk_cordic u_cordic (
		.clk(clk),
		.en(en),
		.vx(vx),
		.vy(vy),
		.angle(angle)
	);

	fwsk_mag u_mag (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.beat_in(vel_beat),
		.vx(vx),
		.vy(vy),
		.radius(cfg_q.wheel_radius),
		.beat_out(mag_beat),
		.rotor(rotor)
	);

	always_ff @(posedge clk) begin
		if (en && mag_beat.valid) begin
			case (mag_beat.wheel)
				WHEEL_FL: begin
					steer_fl_q <= angle;
					rotor_fl_q <= rotor;
				end
				WHEEL_FR: begin
					steer_fr_q <= angle;
					rotor_fr_q <= rotor;
				end
				WHEEL_RL: begin
					steer_rl_q <= angle;
					rotor_rl_q <= rotor;
				end
				WHEEL_RR: begin
					out_q.steer_front_left <= steer_fl_q;
					out_q.steer_front_right <= steer_fr_q;
					out_q.steer_rear_left <= steer_rl_q;
					out_q.steer_rear_right <= angle;
					out_q.rotor_front_left <= rotor_fl_q;
					out_q.rotor_front_right <= rotor_fr_q;
					out_q.rotor_rear_left <= rotor_rl_q;
					out_q.rotor_rear_right <= rotor;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en && mag_beat.valid && mag_beat.wheel == WHEEL_RR) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_q;

endmodule
